>>> rtl/tlbs_pkg.sv
// ----------------------------------------------------------------------------
// tlbs_pkg
// Shared types and constants of the tree lower-bound search block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbs_pkg;

  // Geometry of the node memory and of the keys
  localparam int unsigned NodeCount = 1024;
  localparam int unsigned SlotBits  = 10;
  localparam int unsigned QueryBits = 32;
  localparam int unsigned KeyBits   = QueryBits + 1;

  // Result when no stored key is at or above the query
  localparam logic [KeyBits-1:0] NoBound = {1'b1, {QueryBits{1'b0}}};

  // Last walk step; the walk ends after this node without reading a child
  localparam logic [SlotBits-1:0] VisitLast = SlotBits'(NodeCount - 1);

  // Input transaction kinds
  localparam logic KindWrite  = 1'b0;
  localparam logic KindSearch = 1'b1;

  // One tree node as stored in memory
  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [SlotBits-1:0] left;
    logic [SlotBits-1:0] right;
    logic                internal;
  } node_t;

  // Port request from walker to node memory
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [SlotBits-1:0] addr;
    node_t               wdata;
  } mem_req_t;

  // Walker states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } walk_state_e;

endpackage

`default_nettype wire

>>> rtl/tlbs_node_mem.sv
// ----------------------------------------------------------------------------
// tlbs_node_mem
// Single-port node memory, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbs_node_mem
  import tlbs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output node_t         rdata_o
);

  node_t mem [NodeCount];
  node_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/tlbs_walker.sv
// ----------------------------------------------------------------------------
// tlbs_walker
// Takes input transactions, loads nodes and walks the tree one level a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbs_walker
  import tlbs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [SlotBits-1:0]  node_slot_i,
  input  wire logic [KeyBits-1:0]   node_key_i,
  input  wire logic [SlotBits-1:0]  left_slot_i,
  input  wire logic [SlotBits-1:0]  right_slot_i,
  input  wire logic                 has_children_i,
  input  wire logic [QueryBits-1:0] query_key_i,
  // start slot
  input  wire logic [SlotBits-1:0]  root_i,
  // node memory
  output mem_req_t                  mem_req_o,
  input  wire node_t                mem_rdata_i,
  // result hand-off
  output logic                      res_valid_o,
  output logic [KeyBits-1:0]        res_key_o,
  input  wire logic                 res_take_i
);

  walk_state_e          state_q, state_d;
  logic [QueryBits-1:0] query_q, query_d;
  logic [KeyBits-1:0]   best_q, best_d;
  logic [SlotBits-1:0]  visits_q, visits_d;

  logic                 in_accept;
  logic [KeyBits-1:0]   query_ext;
  logic                 key_eq;
  logic                 key_lt;
  logic                 finish;
  logic [KeyBits-1:0]   best_next;
  logic [SlotBits-1:0]  next_slot;

  assign in_accept = in_valid_i && !in_stall_o;
  assign query_ext = {1'b0, query_q};

  // Compare the node just read against the query
  always_comb begin
    key_eq    = (mem_rdata_i.key == query_ext);
    key_lt    = (mem_rdata_i.key < query_ext);
    finish    = key_eq || !mem_rdata_i.internal || (visits_q == VisitLast);
    next_slot = key_lt ? mem_rdata_i.right : mem_rdata_i.left;
    if (key_eq) begin
      best_next = query_ext;
    end else if (!key_lt) begin
      best_next = mem_rdata_i.key;
    end else begin
      best_next = best_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (kind_i == KindSearch)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (finish) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory port
  always_comb begin
    in_stall_o      = 1'b1;
    res_valid_o     = 1'b0;
    mem_req_o.wr_en = 1'b0;
    mem_req_o.rd_en = 1'b0;
    mem_req_o.addr  = next_slot;
    mem_req_o.wdata = '{key: node_key_i, left: left_slot_i,
                        right: right_slot_i, internal: has_children_i};
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (kind_i == KindWrite) begin
          mem_req_o.wr_en = in_valid_i;
          mem_req_o.addr  = node_slot_i;
        end else begin
          mem_req_o.rd_en = in_valid_i;
          mem_req_o.addr  = root_i;
        end
      end
      ST_WALK: begin
        mem_req_o.rd_en = !finish;
      end
      ST_HOLD: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_key_o = best_q;

  // Walk datapath
  always_comb begin
    query_d  = query_q;
    best_d   = best_q;
    visits_d = visits_q;
    if (state_q == ST_IDLE) begin
      if (in_accept) begin
        query_d  = query_key_i;
        best_d   = NoBound;
        visits_d = '0;
      end
    end else if (state_q == ST_WALK) begin
      best_d   = best_next;
      visits_d = visits_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q  <= query_d;
    best_q   <= best_d;
    visits_q <= visits_d;
  end

endmodule

`default_nettype wire

>>> rtl/tree_lower_bound_search.sv
// ----------------------------------------------------------------------------
// tree_lower_bound_search
// Lower-bound search over a binary search tree held in a node memory.
// ----------------------------------------------------------------------------
//
//   channel  handshake                 payload
//   -------  ------------------------  -----------------------------------
//   in       in_valid_i / in_stall_o   kind, node slot/key/children, query
//   out      out_valid_o / out_stall_i bound_key_o
//   cfg      cfg_we_i                  cfg_wdata_i (root slot)
//
// A node write is a single memory write. A search issues the root read, then
// reads one node memory word per tree level visited, then hands the result to
// the output register. The single memory port sets the pace. Reset clears
// control state only; the node memory holds no defined data until written.
// A stalled result waits in the output register while the next transaction
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lower_bound_search
  import tlbs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [SlotBits-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [SlotBits-1:0]  node_slot_i,
  input  wire logic [KeyBits-1:0]   node_key_i,
  input  wire logic [SlotBits-1:0]  left_slot_i,
  input  wire logic [SlotBits-1:0]  right_slot_i,
  input  wire logic                 has_children_i,
  input  wire logic [QueryBits-1:0] query_key_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [KeyBits-1:0]        bound_key_o
);

  logic [SlotBits-1:0] root_q;
  logic                out_valid_q, out_valid_d;
  logic [KeyBits-1:0]  bound_q, bound_d;

  mem_req_t            mem_req;
  node_t               mem_rdata;
  logic                res_valid;
  logic [KeyBits-1:0]  res_key;
  logic                res_take;

  // Root slot register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  tlbs_walker u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .node_slot_i    (node_slot_i),
    .node_key_i     (node_key_i),
    .left_slot_i    (left_slot_i),
    .right_slot_i   (right_slot_i),
    .has_children_i (has_children_i),
    .query_key_i    (query_key_i),
    .root_i         (root_q),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_key_o      (res_key),
    .res_take_i     (res_take)
  );

  tlbs_node_mem u_node_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    bound_d     = bound_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      bound_d     = res_key;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
  end

  assign out_valid_o = out_valid_q;
  assign bound_key_o = bound_q;

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tree lower-bound search block. Small search
// trees are loaded at the configured root slot and queried around their keys,
// mixed with stray node writes that relink or break the tree. A predictor
// keeps its own node memory and computes every expected bound; results are
// compared in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import tlbs_pkg::*;

  localparam int unsigned CycleLimit   = 5_000_000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseItems   = 375;
  localparam int unsigned MaxTree      = 128;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One input transaction; hold makes the sender wait for all results first
  typedef struct {
    logic                 kind;
    logic [SlotBits-1:0]  slot;
    logic [KeyBits-1:0]   key;
    logic [SlotBits-1:0]  left;
    logic [SlotBits-1:0]  right;
    logic                 internal;
    logic [QueryBits-1:0] query;
    bit                   hold;
  } tree_item_t;

  // DUT connections, all inputs known from time zero
  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [SlotBits-1:0]  cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  wire                  in_stall;
  logic                 kind         = KindWrite;
  logic [SlotBits-1:0]  node_slot    = '0;
  logic [KeyBits-1:0]   node_key     = '0;
  logic [SlotBits-1:0]  left_slot    = '0;
  logic [SlotBits-1:0]  right_slot   = '0;
  logic                 has_children = 1'b0;
  logic [QueryBits-1:0] query_key    = '0;
  wire                  out_valid;
  logic                 out_stall    = 1'b0;
  wire  [KeyBits-1:0]   bound_key;

  // Predictor copy of the block state, updated at acceptance
  logic [KeyBits-1:0]  pred_key   [NodeCount];
  logic [SlotBits-1:0] pred_left  [NodeCount];
  logic [SlotBits-1:0] pred_right [NodeCount];
  logic                pred_int   [NodeCount];
  logic [SlotBits-1:0] pred_root = '0;

  // Generator view of the node memory, used to keep walks on written slots
  logic [KeyBits-1:0]  gen_key     [NodeCount];
  logic [SlotBits-1:0] gen_left    [NodeCount];
  logic [SlotBits-1:0] gen_right   [NodeCount];
  logic                gen_int     [NodeCount];
  bit                  gen_written [NodeCount];
  logic [SlotBits-1:0] gen_root = '0;

  // Last tree built, reused for queries and for stray relinks
  logic [KeyBits-1:0]  tree_keys  [MaxTree];
  logic [SlotBits-1:0] tree_slots [MaxTree];
  int unsigned         tree_size = 0;

  tree_item_t         items_to_send [$];
  tree_item_t         cur_item;
  logic [KeyBits-1:0] bounds_due [$];
  idle_mode_e         mode = IDLE_NONE;

  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned writes_seen     = 0;
  int unsigned searches_seen   = 0;
  int unsigned phase_items     = 0;
  int unsigned phases_run      = 0;

  tree_lower_bound_search u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .node_slot_i    (node_slot),
    .node_key_i     (node_key),
    .left_slot_i    (left_slot),
    .right_slot_i   (right_slot),
    .has_children_i (has_children),
    .query_key_i    (query_key),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .bound_key_o    (bound_key)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  // Lower bound of q over the predictor's tree, walk capped at NodeCount visits
  function automatic logic [KeyBits-1:0] predict_bound(input logic [QueryBits-1:0] q);
    logic [KeyBits-1:0]  best;
    logic [KeyBits-1:0]  qx;
    logic [SlotBits-1:0] pos;
    int unsigned         visits;
    bit                  done;
    best = NoBound;
    qx   = {1'b0, q};
    pos  = pred_root;
    done = 1'b0;
    for (visits = 0; visits < NodeCount && !done; visits++) begin
      if (pred_key[pos] == qx) begin
        best = qx;
        done = 1'b1;
      end else if (!pred_int[pos]) begin
        if (pred_key[pos] > qx) best = pred_key[pos];
        done = 1'b1;
      end else if (pred_key[pos] < qx) begin
        pos = pred_right[pos];
      end else begin
        best = pred_key[pos];
        pos  = pred_left[pos];
      end
    end
    return best;
  endfunction

  // True when a search for q only ever reads slots already written
  function automatic bit walk_stays_written(input logic [QueryBits-1:0] q);
    logic [KeyBits-1:0]  qx;
    logic [SlotBits-1:0] pos;
    int unsigned         visits;
    bit                  ok;
    bit                  done;
    qx   = {1'b0, q};
    pos  = gen_root;
    ok   = 1'b1;
    done = 1'b0;
    for (visits = 0; visits < NodeCount && !done; visits++) begin
      if (!gen_written[pos]) begin
        ok   = 1'b0;
        done = 1'b1;
      end else if (gen_key[pos] == qx || !gen_int[pos]) begin
        done = 1'b1;
      end else if (gen_key[pos] < qx) begin
        pos = gen_right[pos];
      end else begin
        pos = gen_left[pos];
      end
    end
    return ok;
  endfunction

  // Apply one accepted transaction to the predictor
  task automatic apply_item(input tree_item_t it);
    if (it.kind == KindWrite) begin
      pred_key[it.slot]   = it.key;
      pred_left[it.slot]  = it.left;
      pred_right[it.slot] = it.right;
      pred_int[it.slot]   = it.internal;
      writes_seen++;
    end else begin
      bounds_due = {bounds_due, predict_bound(it.query)};
    end
  endtask

  task automatic push_write(input logic [SlotBits-1:0] slot, input logic [KeyBits-1:0] key,
                            input logic [SlotBits-1:0] left, input logic [SlotBits-1:0] right,
                            input logic internal, input bit hold);
    tree_item_t it;
    it.kind     = KindWrite;
    it.slot     = slot;
    it.key      = key;
    it.left     = left;
    it.right    = right;
    it.internal = internal;
    it.query    = $urandom;
    it.hold     = hold;
    items_to_send = {items_to_send, it};
    gen_key[slot]     = key;
    gen_left[slot]    = left;
    gen_right[slot]   = right;
    gen_int[slot]     = internal;
    gen_written[slot] = 1'b1;
    phase_items++;
  endtask

  // Searches that would touch an unwritten slot are dropped
  task automatic push_search(input logic [QueryBits-1:0] q, input bit hold);
    tree_item_t it;
    if (walk_stays_written(q)) begin
      it.kind     = KindSearch;
      it.slot     = SlotBits'($urandom);
      it.key      = KeyBits'({$urandom, $urandom});
      it.left     = SlotBits'($urandom);
      it.right    = SlotBits'($urandom);
      it.internal = 1'($urandom);
      it.query    = q;
      it.hold     = hold;
      items_to_send = {items_to_send, it};
      phase_items++;
    end
  endtask

  // Query near a key of the last tree, at the range ends, or random
  function automatic logic [QueryBits-1:0] pick_query();
    logic [KeyBits-1:0] base;
    if (tree_size == 0) return $urandom;
    base = tree_keys[$urandom_range(tree_size - 1)];
    case ($urandom_range(6))
      0, 1:    return QueryBits'(base);
      2:       return QueryBits'(base - 1'b1);
      3:       return QueryBits'(base + 1'b1);
      4:       return '0;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Sender idles at random by mode
  function automatic bit sender_pause();
    case (mode)
      IDLE_SEND: return $urandom_range(99) < 80;
      IDLE_BOTH: return $urandom_range(99) < 29;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_pause();
    case (mode)
      IDLE_RECV: return $urandom_range(99) < 80;
      IDLE_BOTH: return $urandom_range(99) < 29;
      default:   return 1'b0;
    endcase
  endfunction

  // Wait until every queued transaction is in and every result is out
  task automatic drain();
    while (items_to_send.size() != 0 || in_valid || bounds_due.size() != 0)
      @(negedge clk_i);
  endtask

  // Root register write, only with the block idle
  task automatic set_root(input logic [SlotBits-1:0] root);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= root;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    pred_root = root;
    gen_root  = root;
  endtask

  // Perfect tree in heap order at the root slot, then searches around its keys
  task automatic build_tree_and_search();
    int unsigned     depth;
    int unsigned     n;
    int unsigned     lvl;
    int unsigned     p;
    int unsigned     rank;
    int unsigned     gap_max;
    int unsigned     m;
    logic [9:0]      stride;
    longint unsigned k;
    logic            internal;
    logic [SlotBits-1:0] lc;
    logic [SlotBits-1:0] rc;
    depth  = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4, 1);
    n      = (1 << depth) - 1;
    stride = SlotBits'($urandom) | 10'd1;
    case ($urandom_range(4))
      0:       gap_max = 1;
      1:       gap_max = 3;
      2:       gap_max = 1000;
      3:       gap_max = 1 << 20;
      default: gap_max = 1 << 25;
    endcase
    case ($urandom_range(3))
      0:       k = 0;
      1:       k = $urandom_range(15);
      2:       k = $urandom;
      default: k = 64'hFFFF_FFFF - $urandom_range(200);
    endcase
    for (int j = 0; j < n; j++) begin
      tree_keys[j] = KeyBits'(k);
      k += $urandom_range(gap_max, 1);
    end
    // largest key sometimes a padding node
    if ($urandom_range(4) == 0) tree_keys[n-1] = NoBound;
    for (int i = 1; i <= n; i++) tree_slots[i-1] = gen_root + SlotBits'((i - 1) * stride);
    tree_size = n;
    for (int i = 1; i <= n; i++) begin
      lvl = 0;
      while ((2 << lvl) <= i) lvl++;
      p        = i - (1 << lvl);
      rank     = (2 * p + 1) * (1 << (depth - 1 - lvl)) - 1;
      internal = (lvl < depth - 1);
      lc       = internal ? tree_slots[2*i-1] : SlotBits'($urandom);
      rc       = internal ? tree_slots[2*i]   : SlotBits'($urandom);
      push_write(tree_slots[i-1], tree_keys[rank], lc, rc, internal,
                 i == 1 && $urandom_range(19) == 0);
    end
    m = $urandom_range(10, 3);
    repeat (m) push_search(pick_query(), 1'b0);
  endtask

  // Stray writes: random nodes or relinks inside the last tree
  task automatic scatter_writes();
    logic [SlotBits-1:0] slot;
    logic [SlotBits-1:0] lc;
    logic [SlotBits-1:0] rc;
    logic [KeyBits-1:0]  key;
    repeat ($urandom_range(3, 1)) begin
      if (tree_size != 0 && $urandom_range(1)) begin
        slot = tree_slots[$urandom_range(tree_size - 1)];
        lc   = tree_slots[$urandom_range(tree_size - 1)];
        rc   = tree_slots[$urandom_range(tree_size - 1)];
        key  = tree_keys[$urandom_range(tree_size - 1)] + KeyBits'($urandom_range(2));
      end else begin
        slot = SlotBits'($urandom);
        lc   = SlotBits'($urandom);
        rc   = SlotBits'($urandom);
        key  = KeyBits'({$urandom, $urandom});
      end
      push_write(slot, key, lc, rc, 1'($urandom), 1'b0);
    end
  endtask

  task automatic run_random_phase(input logic [SlotBits-1:0] root, input idle_mode_e m);
    int unsigned choice;
    set_root(root);
    mode        = m;
    phase_items = 0;
    tree_size   = 0;
    phases_run++;
    while (phase_items < PhaseItems) begin
      choice = $urandom_range(99);
      if (choice < 70) begin
        build_tree_and_search();
      end else if (choice < 85) begin
        scatter_writes();
      end else begin
        repeat ($urandom_range(4, 1)) push_search(pick_query(), $urandom_range(49) == 0);
      end
    end
  endtask

  // Directed cases at root slot 0
  task automatic directed_items();
    push_write(10'd0, 33'd100, 10'd1, 10'd2, 1'b1, 1'b0);
    push_write(10'd1, 33'd50, 10'd0, 10'd0, 1'b0, 1'b0);
    push_write(10'd2, 33'd200, 10'd0, 10'd0, 1'b0, 1'b0);
    push_search(32'd100, 1'b0);  // equal at root
    push_search(32'd50, 1'b0);   // equal at leaf
    push_search(32'd0, 1'b0);
    push_search(32'd75, 1'b0);   // candidate from above the leaf
    push_search(32'd150, 1'b0);
    push_search(32'd201, 1'b0);  // nothing at or above
    push_search('1, 1'b0);
    // key above the sentinel, then a padding node
    push_write(10'd2, '1, 10'd0, 10'd0, 1'b0, 1'b0);
    push_search(32'd150, 1'b0);
    push_write(10'd2, NoBound, 10'd0, 10'd0, 1'b0, 1'b0);
    push_search(32'd150, 1'b1);
    // self loop at the root: walk runs out of visits
    push_write(10'd0, 33'd20, 10'd0, 10'd0, 1'b1, 1'b0);
    push_search(32'd10, 1'b0);
    push_search(32'd30, 1'b0);
    push_search(32'd20, 1'b0);
    // all-ones node looping on itself, reached from the root
    push_write('1, '1, '1, '1, 1'b1, 1'b0);
    push_write(10'd0, 33'd5, 10'd0, '1, 1'b1, 1'b0);
    push_search(32'd10, 1'b0);
    // zero key leaf as root
    push_write(10'd0, 33'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    push_search(32'd0, 1'b0);
    push_search(32'd1, 1'b0);
  endtask

  // Input driver: present queued transactions, hold each until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) apply_item(cur_item);
      if (!in_valid || !in_stall) begin
        if (items_to_send.size() != 0 && !sender_pause() &&
            !(items_to_send[0].hold && bounds_due.size() != 0)) begin
          cur_item      = items_to_send.pop_front();
          in_valid     <= 1'b1;
          kind         <= cur_item.kind;
          node_slot    <= cur_item.slot;
          node_key     <= cur_item.key;
          left_slot    <= cur_item.left;
          right_slot   <= cur_item.right;
          has_children <= cur_item.internal;
          query_key    <= cur_item.query;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each result with the oldest expected bound
  always @(posedge clk_i) begin : result_monitor
    logic [KeyBits-1:0] want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (bounds_due.size() == 0) begin
          report_mismatch($sformatf("result with none expected, bound_key=%h", bound_key));
        end else begin
          want = bounds_due.pop_front();
          searches_seen++;
          if (bound_key !== want)
            report_mismatch($sformatf("bound_key=%h expected %h", bound_key, want));
        end
      end
      out_stall <= receiver_pause();
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               bounds_due.size());
      $display("tb failed");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_root('0);
    directed_items();
    run_random_phase('1, IDLE_NONE);
    run_random_phase(SlotBits'($urandom), IDLE_SEND);
    run_random_phase(SlotBits'($urandom), IDLE_RECV);
    run_random_phase(SlotBits'($urandom), IDLE_BOTH);
    run_random_phase('0, IDLE_NONE);
    drain();
    repeat (2 * SettleCycles) @(posedge clk_i);
    $display("covered %0d node writes and %0d checked searches in %0d random phases",
             writes_seen, searches_seen, phases_run);
    $display("roots 0, 1023 and random; idle and stall mixes; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
